>>> rtl/core/bbia_pkg.sv
// shared types and constants of the bitmap block and inode allocator
`timescale 1ns / 1ps

package bbia_pkg;

   // map geometry
   localparam int WORD_W         = 16;
   localparam int NUM_BLOCKS_DEF = 256;
   localparam int NUM_INODES_DEF = 64;

   // reset contents of the block map
   localparam int RESET_DATA_START    = 6;
   localparam int RESET_JOURNAL_START = 254;

   // field widths
   localparam int FUNC_W       = 2;
   localparam int INDEX_W      = 8;
   localparam int STATUS_W     = 2;
   localparam int ENTRY_W      = 8;
   localparam int COUNT_W      = 9;
   localparam int DATA_START_W = 8;
   localparam int JOURNAL_W    = 9;
   localparam int CSR_W        = 9;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 9'h1FF;

   // register indexes
   localparam logic CSR_DATA_START    = 1'b0;
   localparam logic CSR_JOURNAL_START = 1'b1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ALLOC = 2'd0,
      FUNC_FREE  = 2'd1,
      FUNC_COUNT = 2'd2
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NONE    = 2'd1,
      STATUS_IGNORED = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_EVAL,
      S_RESP
   } state_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic eval;
   } cmd_type;

   typedef struct packed {
      logic              clear_last;
      logic [FUNC_W-1:0] func;
      logic              range_empty;
      logic              idx_ok;
      logic              found;
      logic              last_word;
   } dp_status_type;

endpackage

>>> rtl/core/bbia_ctrl.sv
// controller state machine of the allocator
`timescale 1ns / 1ps

module bbia_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output logic                   rsp_strobe,
   output bbia_pkg::cmd_type      cmd,
   input  bbia_pkg::dp_status_type stat
);

   bbia_pkg::state_type state_ff;
   bbia_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bbia_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bbia_pkg::S_CLEAR: begin
            if (stat.clear_last) state_in = bbia_pkg::S_IDLE;
         end
         bbia_pkg::S_IDLE: begin
            if (start) state_in = bbia_pkg::S_CHECK;
         end
         bbia_pkg::S_CHECK: begin
            priority if (stat.func == bbia_pkg::FUNC_ALLOC ||
                         stat.func == bbia_pkg::FUNC_COUNT) begin
               state_in = stat.range_empty ? bbia_pkg::S_RESP : bbia_pkg::S_EVAL;
            end else if (stat.func == bbia_pkg::FUNC_FREE) begin
               state_in = stat.idx_ok ? bbia_pkg::S_EVAL : bbia_pkg::S_RESP;
            end else begin
               state_in = bbia_pkg::S_RESP;
            end
         end
         bbia_pkg::S_EVAL: begin
            priority if (stat.func == bbia_pkg::FUNC_FREE) begin
               state_in = bbia_pkg::S_RESP;
            end else if (stat.func == bbia_pkg::FUNC_ALLOC) begin
               if (stat.found || stat.last_word) state_in = bbia_pkg::S_RESP;
            end else begin
               if (stat.last_word) state_in = bbia_pkg::S_RESP;
            end
         end
         bbia_pkg::S_RESP: begin
            state_in = bbia_pkg::S_IDLE;
         end
         default: begin
            state_in = bbia_pkg::S_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd.clear  = (state_ff == bbia_pkg::S_CLEAR);
      cmd.load   = (state_ff == bbia_pkg::S_IDLE) && start;
      cmd.eval   = (state_ff == bbia_pkg::S_EVAL);
      busy       = (state_ff != bbia_pkg::S_IDLE);
      rsp_strobe = (state_ff == bbia_pkg::S_RESP);
   end

endmodule

>>> rtl/core/bbia_datapath.sv
// datapath of the allocator: registers, map memories and word scan logic
`timescale 1ns / 1ps

module bbia_datapath #(
   parameter int NUM_BLOCKS = bbia_pkg::NUM_BLOCKS_DEF,
   parameter int NUM_INODES = bbia_pkg::NUM_INODES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [bbia_pkg::CSR_W-1:0]          csr_wdata,
   input  logic [bbia_pkg::FUNC_W-1:0]         req_func,
   input  logic                                req_pool,
   input  logic [bbia_pkg::INDEX_W-1:0]        req_index,
   input  bbia_pkg::cmd_type                   cmd,
   output bbia_pkg::dp_status_type             stat,
   output logic [bbia_pkg::STATUS_W-1:0]       rsp_status,
   output logic [bbia_pkg::ENTRY_W-1:0]        rsp_entry,
   output logic [bbia_pkg::COUNT_W-1:0]        rsp_free_total
);

   localparam int WW          = bbia_pkg::WORD_W;
   localparam int WBW         = $clog2(WW);
   localparam int BLOCK_WORDS = (NUM_BLOCKS + WW - 1) / WW;
   localparam int INODE_WORDS = (NUM_INODES + WW - 1) / WW;
   localparam int MAX_WORDS   = (BLOCK_WORDS > INODE_WORDS) ? BLOCK_WORDS : INODE_WORDS;
   localparam int PTRW        = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int BAW         = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
   localparam int IAW         = (INODE_WORDS > 1) ? $clog2(INODE_WORDS) : 1;
   localparam int MAXC        = (NUM_BLOCKS > NUM_INODES) ? NUM_BLOCKS : NUM_INODES;
   localparam int PW0         = $clog2(MAXC + 1);
   localparam int PW          = (PW0 > bbia_pkg::JOURNAL_W) ? PW0 : bbia_pkg::JOURNAL_W;
   localparam int GROUPS      = WW / 4;

   // configuration registers
   logic [bbia_pkg::DATA_START_W-1:0] data_start_ff;
   logic [bbia_pkg::JOURNAL_W-1:0]    journal_start_ff;

   // request and scan registers
   logic [bbia_pkg::FUNC_W-1:0]  func_ff;
   logic                         pool_ff;
   logic [bbia_pkg::INDEX_W-1:0] idx_ff;
   logic [PW-1:0]                lo_ff;
   logic [PW-1:0]                hi_ff;
   logic [PTRW-1:0]              ptr_ff;
   logic [PTRW-1:0]              ptr_in;
   logic [PTRW-1:0]              last_ptr_ff;
   logic [PW-1:0]                acc_ff;
   bbia_pkg::status_type         status_ff;
   logic [bbia_pkg::ENTRY_W-1:0] entry_ff;

   // map memories, one word of used bits per entry
   logic [WW-1:0] block_mem [BLOCK_WORDS];
   logic [WW-1:0] inode_mem [INODE_WORDS];
   logic [WW-1:0] blk_rd_ff;
   logic [WW-1:0] ind_rd_ff;

   // load values
   logic [PW-1:0]   ld_lo;
   logic [PW-1:0]   ld_hi;
   logic [PW-1:0]   js_ext;
   logic [PTRW-1:0] ld_ptr;

   // word evaluation
   logic [WW-1:0]  word;
   logic [WW-1:0]  mask;
   logic [WW-1:0]  free_bits;
   logic [WBW-1:0] first_bit;
   logic           found;
   logic [WBW:0]   pop;
   logic [PW-1:0]  grant_pos;
   logic           last_word;
   logic           advance;

   // write port
   logic [WW-1:0] clr_blk;
   logic [WW-1:0] clr_ind;
   logic [WW-1:0] blk_wdata;
   logic [WW-1:0] ind_wdata;
   logic          blk_we;
   logic          ind_we;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_start_ff    <= bbia_pkg::DATA_START_W'(bbia_pkg::RESET_DATA_START);
         journal_start_ff <= bbia_pkg::JOURNAL_W'(bbia_pkg::RESET_JOURNAL_START);
      end else if (csr_we) begin
         unique case (csr_index)
            bbia_pkg::CSR_DATA_START:    data_start_ff <= csr_wdata[bbia_pkg::DATA_START_W-1:0];
            bbia_pkg::CSR_JOURNAL_START: journal_start_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      js_ext = PW'(journal_start_ff);
      if (req_pool) begin
         ld_lo = '0;
         ld_hi = PW'(NUM_INODES);
      end else begin
         ld_lo = PW'(data_start_ff);
         ld_hi = (js_ext < PW'(NUM_BLOCKS)) ? js_ext : PW'(NUM_BLOCKS);
      end
      if (req_func == bbia_pkg::FUNC_FREE) begin
         ld_ptr = PTRW'(req_index >> WBW);
      end else begin
         ld_ptr = PTRW'(ld_lo >> WBW);
      end
   end

   always_comb begin
      logic [PW-1:0]  pos;
      logic [2:0]     grp;
      word      = pool_ff ? ind_rd_ff : blk_rd_ff;
      first_bit = '0;
      pop       = '0;
      clr_blk   = '0;
      clr_ind   = '0;
      for (int b = 0; b < WW; b++) begin
         pos        = PW'({ptr_ff, WBW'(b)});
         mask[b]    = (pos >= lo_ff) && (pos < hi_ff);
         clr_blk[b] = (pos < PW'(bbia_pkg::RESET_DATA_START)) ||
                      (pos >= PW'(bbia_pkg::RESET_JOURNAL_START));
         clr_ind[b] = (pos == '0);
      end
      free_bits = ~word & mask;
      found     = |free_bits;
      // lowest free bit wins
      for (int b = WW - 1; b >= 0; b--) begin
         if (free_bits[b]) first_bit = WBW'(b);
      end
      for (int g = 0; g < GROUPS; g++) begin
         grp = 3'(free_bits[4*g]) + 3'(free_bits[4*g+1]) +
               3'(free_bits[4*g+2]) + 3'(free_bits[4*g+3]);
         pop = pop + (WBW+1)'(grp);
      end
      grant_pos = PW'({ptr_ff, first_bit});
   end

   assign last_word = (ptr_ff == last_ptr_ff);
   assign advance   = cmd.eval && !last_word &&
                      ((func_ff == bbia_pkg::FUNC_COUNT) ||
                       ((func_ff == bbia_pkg::FUNC_ALLOC) && !found));

   always_comb begin
      blk_wdata = clr_blk;
      ind_wdata = clr_ind;
      blk_we    = 1'b0;
      ind_we    = 1'b0;
      priority if (cmd.clear) begin
         blk_we = (ptr_ff <= PTRW'(BLOCK_WORDS - 1));
         ind_we = (ptr_ff <= PTRW'(INODE_WORDS - 1));
      end else if (cmd.eval && (func_ff == bbia_pkg::FUNC_ALLOC) && found) begin
         blk_wdata = word | (WW'(1) << first_bit);
         ind_wdata = blk_wdata;
         blk_we    = !pool_ff;
         ind_we    = pool_ff;
      end else if (cmd.eval && (func_ff == bbia_pkg::FUNC_FREE)) begin
         blk_wdata = word & ~(WW'(1) << idx_ff[WBW-1:0]);
         ind_wdata = blk_wdata;
         blk_we    = !pool_ff;
         ind_we    = pool_ff;
      end else begin
         blk_we = 1'b0;
      end
   end

   always_comb begin
      priority if (cmd.clear) begin
         ptr_in = ptr_ff + 1'b1;
      end else if (cmd.load) begin
         ptr_in = ld_ptr;
      end else if (advance) begin
         ptr_in = ptr_ff + 1'b1;
      end else begin
         ptr_in = ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
      end
   end

   // read port follows the next pointer so the read word lines up with the registered pointer
   always_ff @(posedge clock) begin
      blk_rd_ff <= block_mem[ptr_in[BAW-1:0]];
      ind_rd_ff <= inode_mem[ptr_in[IAW-1:0]];
      if (blk_we) block_mem[ptr_ff[BAW-1:0]] <= blk_wdata;
      if (ind_we) inode_mem[ptr_ff[IAW-1:0]] <= ind_wdata;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff     <= req_func;
         pool_ff     <= req_pool;
         idx_ff      <= req_index;
         lo_ff       <= ld_lo;
         hi_ff       <= ld_hi;
         last_ptr_ff <= PTRW'((ld_hi - 1'b1) >> WBW);
         acc_ff      <= '0;
         entry_ff    <= '0;
         unique case (req_func)
            bbia_pkg::FUNC_ALLOC: status_ff <= bbia_pkg::STATUS_NONE;
            bbia_pkg::FUNC_COUNT: status_ff <= bbia_pkg::STATUS_OK;
            default:              status_ff <= bbia_pkg::STATUS_IGNORED;
         endcase
      end else if (cmd.eval) begin
         if (func_ff == bbia_pkg::FUNC_ALLOC && found) begin
            status_ff <= bbia_pkg::STATUS_OK;
            entry_ff  <= grant_pos[bbia_pkg::ENTRY_W-1:0];
         end
         if (func_ff == bbia_pkg::FUNC_FREE) status_ff <= bbia_pkg::STATUS_OK;
         if (func_ff == bbia_pkg::FUNC_COUNT) acc_ff <= acc_ff + PW'(pop);
      end
   end

   always_comb begin
      stat.clear_last  = (ptr_ff == PTRW'(MAX_WORDS - 1));
      stat.func        = func_ff;
      stat.range_empty = (lo_ff >= hi_ff);
      stat.idx_ok      = (PW'(idx_ff) >= lo_ff) && (PW'(idx_ff) < hi_ff);
      stat.found       = found;
      stat.last_word   = last_word;
   end

   assign rsp_status     = status_ff;
   assign rsp_entry      = entry_ff;
   assign rsp_free_total = (acc_ff > PW'(bbia_pkg::COUNT_MAX)) ? bbia_pkg::COUNT_MAX
                                                             : acc_ff[bbia_pkg::COUNT_W-1:0];

endmodule

>>> rtl/core/bitmap_block_inode_allocator_core.sv
// top level of the bitmap block and inode allocator
// a request passes a check state, one scan state per 16-bit word (a single word for an in-range
//   free) and a result state; an ignored request or an empty-range allocate or count skips the scan
// throughput: one request at a time, the next start is taken the cycle after the strobe
// reset: a clearing pass writes the formatted map contents, one word of each map a cycle,
//   over max(ceil(NUM_BLOCKS/16), ceil(NUM_INODES/16)) words (16 by default), busy high meanwhile
// results are strobed for one cycle; the receiver cannot stall
`timescale 1ns / 1ps

module bitmap_block_inode_allocator_core #(
   parameter int NUM_BLOCKS = bbia_pkg::NUM_BLOCKS_DEF,
   parameter int NUM_INODES = bbia_pkg::NUM_INODES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [bbia_pkg::FUNC_W-1:0]   req_func,
   input  logic                          req_pool,
   input  logic [bbia_pkg::INDEX_W-1:0]  req_index,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [bbia_pkg::CSR_W-1:0]    csr_wdata,
   output logic                          rsp_strobe,
   output logic [bbia_pkg::STATUS_W-1:0] rsp_status,
   output logic [bbia_pkg::ENTRY_W-1:0]  rsp_entry,
   output logic [bbia_pkg::COUNT_W-1:0]  rsp_free_total
);

   bbia_pkg::cmd_type       cmd;
   bbia_pkg::dp_status_type stat;

   bbia_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .stat       (stat)
   );

   bbia_datapath #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .NUM_INODES (NUM_INODES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_func       (req_func),
      .req_pool       (req_pool),
      .req_index      (req_index),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_status     (rsp_status),
      .rsp_entry      (rsp_entry),
      .rsp_free_total (rsp_free_total)
   );

endmodule

>>> rtl/core/bbia_checker.sv
// port-level assertions of the allocator and their bind
`timescale 1ns / 1ps

module bbia_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_strobe,
   input logic [bbia_pkg::STATUS_W-1:0] rsp_status,
   input logic [bbia_pkg::ENTRY_W-1:0]  rsp_entry,
   input logic [bbia_pkg::COUNT_W-1:0]  rsp_free_total
);

   // a transfer starts work
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy low after accepted request");

   // a result only comes out of an accepted request
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe while idle");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy && !rsp_strobe)
      else $error("block not idle after result");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == bbia_pkg::STATUS_NONE |->
         rsp_entry == '0 && rsp_free_total == '0)
      else $error("none free result carries data");

endmodule

bind bitmap_block_inode_allocator_core bbia_checker u_bbia_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_status     (rsp_status),
   .rsp_entry      (rsp_entry),
   .rsp_free_total (rsp_free_total)
);

>>> tb/bitmap_block_inode_allocator_core_test.sv
// testbench for the bitmap block and inode allocator core
`timescale 1ns / 1ps

module bitmap_block_inode_allocator_core_test;
   import bbia_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int BLOCKS         = 256;
   localparam int INODES         = 64;
   localparam int SETTLE_CYCLES  = 4;
   localparam int TAIL_CYCLES    = 20;
   localparam int STALL_LIMIT    = 500;
   localparam int PHASE_ITEMS    = 92;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ENTRY_W-1:0]  entry;
      logic [COUNT_W-1:0]  free_total;
   } alloc_result_type;

   typedef enum logic {ROW_REQ, ROW_CFG} row_kind_type;

   typedef struct {
      row_kind_type        kind;
      logic [FUNC_W-1:0]   func;
      logic                pool;
      logic [INDEX_W-1:0]  index;
      bit                  typed;
      alloc_result_type    want;
      logic [7:0]          ds;
      logic [8:0]          js;
   } plan_row_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [FUNC_W-1:0]   req_func;
   logic                req_pool;
   logic [INDEX_W-1:0]  req_index;
   logic                csr_we;
   logic                csr_index;
   logic [CSR_W-1:0]    csr_wdata;
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [ENTRY_W-1:0]  rsp_entry;
   logic [COUNT_W-1:0]  rsp_free_total;

   // predictor state
   bit                  pool_used [2][BLOCKS];
   logic [7:0]          ds_reg;
   logic [8:0]          js_reg;
   alloc_result_type    pending_results [$];

   int errors;
   int n_requests;
   int n_results;
   int n_grants;
   int n_none_free;
   int n_ignored;
   int n_counts;
   int n_settings;
   int stall_cycles;

   bitmap_block_inode_allocator_core u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_pool       (req_pool),
      .req_index      (req_index),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_entry      (rsp_entry),
      .rsp_free_total (rsp_free_total)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void format_maps();
      for (int i = 0; i < BLOCKS; i++) begin
         pool_used[0][i] = (i < RESET_DATA_START) || (i >= RESET_JOURNAL_START);
         pool_used[1][i] = (i == 0);
      end
      ds_reg = 8'(RESET_DATA_START);
      js_reg = 9'(RESET_JOURNAL_START);
   endfunction

   function automatic void pool_bounds(input logic p, output int lo, output int hi);
      if (p) begin
         lo = 0;
         hi = INODES;
      end else begin
         lo = int'(ds_reg);
         hi = (int'(js_reg) < BLOCKS) ? int'(js_reg) : BLOCKS;
      end
   endfunction

   function automatic alloc_result_type model_request(input logic [FUNC_W-1:0] f, input logic p,
                                                      input logic [INDEX_W-1:0] idx);
      alloc_result_type r;
      int lo, hi, n;
      r.status = STATUS_IGNORED;
      r.entry = '0;
      r.free_total = '0;
      pool_bounds(p, lo, hi);
      case (f)
         FUNC_ALLOC: begin
            r.status = STATUS_NONE;
            for (int i = lo; i < hi; i++) begin
               if (!pool_used[p][i]) begin
                  pool_used[p][i] = 1'b1;
                  r.status = STATUS_OK;
                  r.entry = 8'(i);
                  break;
               end
            end
         end
         FUNC_FREE: begin
            if (int'(idx) >= lo && int'(idx) < hi) begin
               pool_used[p][idx] = 1'b0;
               r.status = STATUS_OK;
            end
         end
         FUNC_COUNT: begin
            n = 0;
            for (int i = lo; i < hi; i++)
               if (!pool_used[p][i]) n++;
            r.free_total = (n > int'(COUNT_MAX)) ? COUNT_MAX : 9'(n);
            r.status = STATUS_OK;
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic plan_row_type row_req(input logic [FUNC_W-1:0] f, input logic p,
                                            input logic [INDEX_W-1:0] idx);
      plan_row_type r;
      r.kind = ROW_REQ;
      r.func = f;
      r.pool = p;
      r.index = idx;
      r.typed = 1'b0;
      r.want = '0;
      r.ds = '0;
      r.js = '0;
      return r;
   endfunction

   function automatic plan_row_type row_known(input logic [FUNC_W-1:0] f, input logic p,
                                              input logic [INDEX_W-1:0] idx,
                                              input logic [STATUS_W-1:0] st,
                                              input logic [ENTRY_W-1:0] e,
                                              input logic [COUNT_W-1:0] c);
      plan_row_type r;
      r = row_req(f, p, idx);
      r.typed = 1'b1;
      r.want.status = st;
      r.want.entry = e;
      r.want.free_total = c;
      return r;
   endfunction

   function automatic plan_row_type row_cfg(input logic [7:0] ds, input logic [8:0] js);
      plan_row_type r;
      r = row_req(FUNC_COUNT, 1'b0, '0);
      r.kind = ROW_CFG;
      r.ds = ds;
      r.js = js;
      return r;
   endfunction

   // start stays high after the transfer; the caller lowers it or sends the next request
   task automatic issue_request(input logic [FUNC_W-1:0] f, input logic p,
                                input logic [INDEX_W-1:0] idx,
                                input bit typed, input alloc_result_type want);
      alloc_result_type predicted;
      req_func <= f;
      req_pool <= p;
      req_index <= idx;
      start <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      predicted = model_request(f, p, idx);
      pending_results.push_back(typed ? want : predicted);
      n_requests++;
      case (predicted.status)
         STATUS_NONE:    n_none_free++;
         STATUS_IGNORED: n_ignored++;
         default: begin
            if (f == FUNC_ALLOC) n_grants++;
            if (f == FUNC_COUNT) n_counts++;
         end
      endcase
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // both registers every time; start is low here
   task automatic program_limits(input logic [7:0] ds, input logic [8:0] js);
      csr_we <= 1'b1;
      csr_index <= CSR_DATA_START;
      csr_wdata <= {1'($urandom_range(0, 1)), ds};
      @(posedge clock);
      ds_reg = ds;
      csr_index <= CSR_JOURNAL_START;
      csr_wdata <= js;
      @(posedge clock);
      js_reg = js;
      csr_we <= 1'b0;
      n_settings++;
   endtask

   always @(posedge clock) begin : check_results
      alloc_result_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         n_results++;
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: result with nothing expected: status %0d entry %0d count %0d",
                     $time, rsp_status, rsp_entry, rsp_free_total);
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               errors++;
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
            end
            if (rsp_entry !== want.entry) begin
               errors++;
               $display("%0t: entry expected %0d actual %0d", $time, want.entry, rsp_entry);
            end
            if (rsp_free_total !== want.free_total) begin
               errors++;
               $display("%0t: free total expected %0d actual %0d",
                        $time, want.free_total, rsp_free_total);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start === 1'b1 && busy === 1'b0) || rsp_strobe === 1'b1 || csr_we)
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("bitmap_block_inode_allocator_core test failed");
         $finish;
      end
   end

   initial begin : stimulus
      plan_row_type plan [$];
      logic [7:0] phase_ds [$];
      logic [8:0] phase_js [$];
      logic [FUNC_W-1:0] f;
      logic p;
      logic [INDEX_W-1:0] idx;
      int roll, lo, hi;
      bit quiet;

      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_func = '0;
      req_pool = 1'b0;
      req_index = '0;
      csr_we = 1'b0;
      csr_index = CSR_DATA_START;
      csr_wdata = '0;
      errors = 0;
      n_requests = 0;
      n_results = 0;
      n_grants = 0;
      n_none_free = 0;
      n_ignored = 0;
      n_counts = 0;
      n_settings = 0;
      stall_cycles = 0;
      format_maps();

      // formatted disk: blocks 6..253 and inodes 1..63 free
      plan.push_back(row_known(FUNC_COUNT, 1'b0, 8'd0, STATUS_OK, 8'd0, 9'd248));
      plan.push_back(row_known(FUNC_COUNT, 1'b1, 8'd255, STATUS_OK, 8'd0, 9'd63));
      plan.push_back(row_known(FUNC_ALLOC, 1'b0, 8'd0, STATUS_OK, 8'd6, 9'd0));
      plan.push_back(row_known(FUNC_ALLOC, 1'b1, 8'd0, STATUS_OK, 8'd1, 9'd0));
      plan.push_back(row_known(FUNC_FREE, 1'b0, 8'd0, STATUS_IGNORED, 8'd0, 9'd0));
      plan.push_back(row_known(FUNC_FREE, 1'b0, 8'd255, STATUS_IGNORED, 8'd0, 9'd0));
      plan.push_back(row_known(FUNC_FREE, 1'b0, 8'd254, STATUS_IGNORED, 8'd0, 9'd0));
      // freeing an entry that is already free
      plan.push_back(row_known(FUNC_FREE, 1'b0, 8'd253, STATUS_OK, 8'd0, 9'd0));
      plan.push_back(row_known(FUNC_FREE, 1'b0, 8'd6, STATUS_OK, 8'd0, 9'd0));
      plan.push_back(row_known(FUNC_FREE, 1'b1, 8'd64, STATUS_IGNORED, 8'd0, 9'd0));
      plan.push_back(row_known(FUNC_FREE, 1'b1, 8'd255, STATUS_IGNORED, 8'd0, 9'd0));
      plan.push_back(row_known(FUNC_FREE, 1'b1, 8'd0, STATUS_OK, 8'd0, 9'd0));
      plan.push_back(row_known(FUNC_ALLOC, 1'b1, 8'd0, STATUS_OK, 8'd0, 9'd0));
      plan.push_back(row_known(FUNC_UNUSED, 1'b0, 8'd255, STATUS_IGNORED, 8'd0, 9'd0));
      plan.push_back(row_known(FUNC_UNUSED, 1'b1, 8'd0, STATUS_IGNORED, 8'd0, 9'd0));
      plan.push_back(row_req(FUNC_ALLOC, 1'b0, 8'd170));
      plan.push_back(row_req(FUNC_COUNT, 1'b1, 8'd85));
      // data start above journal start: block range empty
      plan.push_back(row_cfg(8'd200, 9'd100));
      plan.push_back(row_known(FUNC_ALLOC, 1'b0, 8'd0, STATUS_NONE, 8'd0, 9'd0));
      plan.push_back(row_known(FUNC_COUNT, 1'b0, 8'd0, STATUS_OK, 8'd0, 9'd0));
      plan.push_back(row_known(FUNC_FREE, 1'b0, 8'd150, STATUS_IGNORED, 8'd0, 9'd0));
      // whole map allocatable
      plan.push_back(row_cfg(8'd0, 9'd256));
      plan.push_back(row_known(FUNC_FREE, 1'b0, 8'd0, STATUS_OK, 8'd0, 9'd0));
      plan.push_back(row_known(FUNC_ALLOC, 1'b0, 8'd0, STATUS_OK, 8'd0, 9'd0));
      plan.push_back(row_req(FUNC_COUNT, 1'b0, 8'd0));
      // journal start past the map end is clamped
      plan.push_back(row_cfg(8'd255, 9'd511));
      plan.push_back(row_req(FUNC_COUNT, 1'b0, 8'd0));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CFG) begin
            drain_results();
            program_limits(plan[i].ds, plan[i].js);
         end else begin
            issue_request(plan[i].func, plan[i].pool, plan[i].index, plan[i].typed,
                          plan[i].want);
         end
      end

      phase_ds = '{8'd6, 8'd0, 8'd255, 8'd0, 8'd0, 8'd128};
      phase_js = '{9'd254, 9'd256, 9'd256, 9'd8, 9'd0, 9'd511};
      repeat (2) begin
         phase_ds.push_back(8'($urandom_range(0, 255)));
         phase_js.push_back(9'($urandom_range(0, 256)));
      end
      phase_ds.push_back(8'($urandom_range(0, 255)));
      phase_js.push_back(9'($urandom_range(0, 511)));

      foreach (phase_ds[ph]) begin
         drain_results();
         program_limits(phase_ds[ph], phase_js[ph]);
         quiet = (ph == 1);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            roll = $urandom_range(0, 99);
            p = 1'($urandom_range(0, 1));
            if (roll < 45)      f = FUNC_ALLOC;
            else if (roll < 80) f = FUNC_FREE;
            else if (roll < 95) f = FUNC_COUNT;
            else                f = FUNC_UNUSED;
            pool_bounds(p, lo, hi);
            // mostly frees inside the pool range so that entries get recycled
            if (lo < hi && $urandom_range(0, 9) < 7)
               idx = 8'($urandom_range(lo, hi - 1));
            else
               idx = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 99) == 0) begin
               drain_results();
            end else if (!quiet && $urandom_range(0, 99) < 18) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 24)) @(posedge clock);
            end
            issue_request(f, p, idx, 1'b0, '0);
         end
      end

      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         errors++;
         $display("%0t: %0d results never arrived", $time, pending_results.size());
      end

      $display("%0d requests, %0d results under %0d limit settings", n_requests, n_results,
               n_settings);
      $display("%0d grants, %0d none free, %0d ignored, %0d counts, %0d mismatches",
               n_grants, n_none_free, n_ignored, n_counts, errors);
      if (errors == 0)
         $display("bitmap_block_inode_allocator_core test passed");
      else
         $display("bitmap_block_inode_allocator_core test failed");
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/bbia_pkg.sv
rtl/core/bbia_ctrl.sv
rtl/core/bbia_datapath.sv
rtl/core/bitmap_block_inode_allocator_core.sv
rtl/core/bbia_checker.sv
tb/bitmap_block_inode_allocator_core_test.sv
